### design/art_pkg.sv
package art_pkg;

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_ZERO    = 8'h30;

    localparam logic [2:0] FIELD_SOURCE = 3'd1;
    localparam logic [2:0] FIELD_START  = 3'd2;
    localparam logic [2:0] FIELD_SPAN   = 3'd3;
    localparam logic [2:0] FIELD_STRAND = 3'd4;
    localparam logic [2:0] FIELD_CONTIG = 3'd5;
    localparam logic [2:0] FIELD_SEQ    = 3'd6;
    localparam logic [2:0] FIELD_SAT    = 3'd7;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    // output queue depth, must leave room for two pushes per cycle
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        EV_SOURCE = 2'd0,
        EV_SEQ    = 2'd1,
        EV_RECORD = 2'd2,
        EV_BLOCK  = 2'd3
    } event_t;

    typedef struct packed {
        event_t      event_res;
        logic [7:0]  char_out;
        logic [31:0] start_pos;
        logic [31:0] span_len;
        logic [7:0]  strand_char;
        logic [31:0] contig_len;
        logic [15:0] records_in_block;
        logic [15:0] max_records;
    } result_t;

    // results produced by one byte, packed from result0 upward
    typedef struct packed {
        logic    push0;
        logic    push1;
        result_t result0;
        result_t result1;
    } push_t;

endpackage

### design/art_if.sv
interface art_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;

    modport source (output valid, output char_in, input ready);
    modport sink (input valid, input char_in, output ready);
endinterface

interface art_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  event_res;
    logic [7:0]  char_out;
    logic [31:0] start_pos;
    logic [31:0] span_len;
    logic [7:0]  strand_char;
    logic [31:0] contig_len;
    logic [15:0] records_in_block;
    logic [15:0] max_records;

    modport source (
        output valid, output event_res, output char_out, output start_pos,
        output span_len, output strand_char, output contig_len,
        output records_in_block, output max_records, input ready
    );
    modport sink (
        input valid, input event_res, input char_out, input start_pos,
        input span_len, input strand_char, input contig_len,
        input records_in_block, input max_records, output ready
    );
endinterface

### design/art_core.sv
module art_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [7:0]        in_char,
    output logic              in_ready,
    input  logic              room,
    output art_pkg::push_t    push
);

    logic        hold_valid_reg;
    logic [7:0]  hold_char_reg;
    logic        take;

    logic [2:0]  field_index_reg, field_index_next;
    logic        prev_space_reg, prev_space_next;
    logic        line_start_reg, line_start_next;
    logic        has_byte_reg, has_byte_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] start_reg, start_next;
    logic [31:0] span_reg, span_next;
    logic [7:0]  strand_reg, strand_next;
    logic [31:0] contig_reg, contig_next;
    logic [15:0] count_reg, count_next;
    logic [15:0] max_reg, max_next;

    logic [7:0]  c;
    logic [31:0] acc_ten;
    logic [15:0] count_inc;
    logic        is_record;
    art_pkg::result_t res_rec, res_blk, res_byte;

    assign take     = hold_valid_reg && room;
    assign in_ready = !hold_valid_reg || room;
    assign c        = hold_char_reg;
    assign acc_ten  = {acc_reg[28:0], 3'b000} + {acc_reg[30:0], 1'b0}
                    + {24'd0, c} - {24'd0, art_pkg::CH_ZERO};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            hold_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            hold_char_reg <= in_char;
        end
    end

    always_comb
    begin
        field_index_next = field_index_reg;
        prev_space_next  = prev_space_reg;
        line_start_next  = line_start_reg;
        has_byte_next    = has_byte_reg;
        acc_next         = acc_reg;
        start_next       = start_reg;
        span_next        = span_reg;
        strand_next      = strand_reg;
        contig_next      = contig_reg;
        count_next       = count_reg;
        max_next         = max_reg;
        is_record        = (field_index_reg == art_pkg::FIELD_SEQ);
        count_inc        = count_reg;
        res_rec          = '0;
        res_blk          = '0;
        res_byte         = '0;
        push             = '0;

        if (c == art_pkg::CH_SPACE)
        begin
            if (!prev_space_reg)
            begin
                unique case (field_index_reg)
                    art_pkg::FIELD_START:  start_next  = acc_reg;
                    art_pkg::FIELD_SPAN:   span_next   = acc_reg;
                    art_pkg::FIELD_STRAND: strand_next = has_byte_reg ? acc_reg[7:0] : 8'd0;
                    art_pkg::FIELD_CONTIG: contig_next = acc_reg;
                    default: ;
                endcase
                if (field_index_reg != art_pkg::FIELD_SAT)
                begin
                    field_index_next = field_index_reg + 3'd1;
                end
                acc_next      = '0;
                has_byte_next = 1'b0;
            end
            prev_space_next = 1'b1;
        end
        else if (c == art_pkg::CH_NEWLINE)
        begin
            prev_space_next = 1'b0;
            if (is_record && count_reg != art_pkg::COUNT_MAX)
            begin
                count_inc = count_reg + 16'd1;
            end
            count_next = count_inc;
            res_rec.event_res   = art_pkg::EV_RECORD;
            res_rec.start_pos   = start_reg;
            res_rec.span_len    = span_reg;
            res_rec.strand_char = strand_reg;
            res_rec.contig_len  = contig_reg;
            res_rec.max_records = max_reg;
            if (line_start_reg)
            begin
                if (count_inc > max_reg)
                begin
                    max_next = count_inc;
                end
                count_next = '0;
            end
            res_blk.event_res        = art_pkg::EV_BLOCK;
            res_blk.records_in_block = count_inc;
            res_blk.max_records      = max_next;
            priority if (is_record)
            begin
                push.push0   = 1'b1;
                push.result0 = res_rec;
                push.push1   = line_start_reg;
                push.result1 = res_blk;
            end
            else
            begin
                push.push0   = line_start_reg;
                push.result0 = res_blk;
            end
            line_start_next  = 1'b1;
            field_index_next = '0;
            acc_next         = '0;
            has_byte_next    = 1'b0;
        end
        else if (c == art_pkg::CH_HASH)
        begin
            prev_space_next = 1'b0;
        end
        else if (line_start_reg)
        begin
            // first ordinary byte of a line is the line tag
            prev_space_next = 1'b0;
            line_start_next = 1'b0;
        end
        else
        begin
            prev_space_next      = 1'b0;
            has_byte_next        = 1'b1;
            res_byte.char_out    = c;
            res_byte.max_records = max_reg;
            unique case (field_index_reg)
                art_pkg::FIELD_SOURCE:
                begin
                    res_byte.event_res = art_pkg::EV_SOURCE;
                    push.push0         = 1'b1;
                end
                art_pkg::FIELD_START, art_pkg::FIELD_SPAN, art_pkg::FIELD_CONTIG:
                begin
                    acc_next = acc_ten;
                end
                art_pkg::FIELD_STRAND:
                begin
                    if (!has_byte_reg)
                    begin
                        acc_next = {24'd0, c};
                    end
                end
                art_pkg::FIELD_SEQ:
                begin
                    res_byte.event_res = art_pkg::EV_SEQ;
                    push.push0         = 1'b1;
                end
                default: ;
            endcase
            push.result0 = res_byte;
        end

        if (!take)
        begin
            push.push0 = 1'b0;
            push.push1 = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_index_reg <= '0;
            prev_space_reg  <= 1'b1;
            line_start_reg  <= 1'b1;
            has_byte_reg    <= 1'b0;
            acc_reg         <= '0;
            start_reg       <= '0;
            span_reg        <= '0;
            strand_reg      <= '0;
            contig_reg      <= '0;
            count_reg       <= '0;
            max_reg         <= '0;
        end
        else if (take)
        begin
            field_index_reg <= field_index_next;
            prev_space_reg  <= prev_space_next;
            line_start_reg  <= line_start_next;
            has_byte_reg    <= has_byte_next;
            acc_reg         <= acc_next;
            start_reg       <= start_next;
            span_reg        <= span_next;
            strand_reg      <= strand_next;
            contig_reg      <= contig_next;
            count_reg       <= count_next;
            max_reg         <= max_next;
        end
    end

endmodule

### design/art_queue.sv
module art_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  art_pkg::push_t    push,
    output logic              room,
    output logic              out_valid,
    input  logic              out_ready,
    output art_pkg::result_t  out_result
);

    localparam int PtrW = $clog2(art_pkg::QUEUE_DEPTH);
    localparam int CntW = $clog2(art_pkg::QUEUE_DEPTH + 1);

    art_pkg::result_t mem_reg [art_pkg::QUEUE_DEPTH];
    logic [PtrW-1:0]  head_reg, head_next;
    logic [PtrW-1:0]  tail_reg, tail_next;
    logic [CntW-1:0]  count_reg, count_next;
    logic             pop;
    logic [PtrW-1:0]  tail_plus;

    assign out_valid  = (count_reg != '0);
    assign out_result = mem_reg[head_reg];
    assign pop        = out_valid && out_ready;
    // two free slots needed, a newline may push two words
    assign room       = (count_reg <= CntW'(art_pkg::QUEUE_DEPTH - 2));
    assign tail_plus  = tail_reg + PtrW'(1);

    always_comb
    begin
        head_next  = pop ? head_reg + PtrW'(1) : head_reg;
        tail_next  = tail_reg;
        count_next = count_reg - CntW'(pop);
        if (push.push0)
        begin
            tail_next  = tail_plus;
            count_next = count_next + CntW'(1);
        end
        if (push.push1)
        begin
            tail_next  = tail_plus + PtrW'(1);
            count_next = count_next + CntW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.push0)
        begin
            mem_reg[tail_reg] <= push.result0;
        end
        if (push.push1)
        begin
            mem_reg[tail_plus] <= push.result1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

endmodule

### design/alignment_record_tokenizer_top.sv
// alignment record tokenizer: takes one text byte per word on char_ch and
// emits tagged words on result_ch. source and sequence bytes stream out as
// they arrive; a newline closing a seven-field line emits a record-done word
// with the start, length, strand and contig values of that line, and a
// newline on an empty line emits a block-done word with the record count.
// a newline can close a record and a block at once and then gives two
// words. one byte is taken every clock cycle while the queue has room. the
// byte is captured in an input register, the tokenizer state is updated in
// one pass and its words land in a four-word output queue that drives
// result_ch directly. the queue only takes a byte while two words are free;
// the sustained rate is one word per cycle while result_ch is ready.
// sequence bytes of a line that turns out not to be a record have already
// gone out; the consumer drops them. there is no clearing pass, the block
// is ready right after reset.
module alignment_record_tokenizer_top (
    input  logic           clk,
    input  logic           rst_n,
    art_char_if.sink       char_ch,
    art_result_if.source   result_ch
);

    logic             room;
    logic             queue_valid;
    art_pkg::push_t   push;
    art_pkg::result_t queue_result;

    // input register and tokenizer state
    art_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (char_ch.valid),
        .in_char  (char_ch.char_in),
        .in_ready (char_ch.ready),
        .room     (room),
        .push     (push)
    );

    // output queue, decouples stalls on result_ch from the byte stream
    art_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .room       (room),
        .out_valid  (queue_valid),
        .out_ready  (result_ch.ready),
        .out_result (queue_result)
    );

    assign result_ch.valid            = queue_valid;
    assign result_ch.event_res        = queue_result.event_res;
    assign result_ch.char_out         = queue_result.char_out;
    assign result_ch.start_pos        = queue_result.start_pos;
    assign result_ch.span_len         = queue_result.span_len;
    assign result_ch.strand_char      = queue_result.strand_char;
    assign result_ch.contig_len       = queue_result.contig_len;
    assign result_ch.records_in_block = queue_result.records_in_block;
    assign result_ch.max_records      = queue_result.max_records;

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;

    // predicts the tokenizer words and checks them in order of arrival
    class tokenizer_scoreboard;
        logic [2:0]       field_index;
        bit               prev_space;
        bit               line_start;
        bit               field_has_byte;
        logic [31:0]      number_acc;
        logic [31:0]      start_hold;
        logic [31:0]      length_hold;
        logic [7:0]       strand_hold;
        logic [31:0]      contig_hold;
        logic [15:0]      block_count;
        logic [15:0]      max_count;
        art_pkg::result_t pending_words[$];
        int unsigned      mismatches;

        function new();
            field_index    = '0;
            prev_space     = 1'b1;
            line_start     = 1'b1;
            field_has_byte = 1'b0;
            number_acc     = '0;
            start_hold     = '0;
            length_hold    = '0;
            strand_hold    = '0;
            contig_hold    = '0;
            block_count    = '0;
            max_count      = '0;
            mismatches     = 0;
        endfunction

        function void push_word(art_pkg::event_t ev, logic [7:0] ch, logic [15:0] recs);
            art_pkg::result_t w;
            w                  = '0;
            w.event_res        = ev;
            w.char_out         = ch;
            w.records_in_block = recs;
            w.max_records      = max_count;
            if (ev == art_pkg::EV_RECORD)
            begin
                w.start_pos   = start_hold;
                w.span_len    = length_hold;
                w.strand_char = strand_hold;
                w.contig_len  = contig_hold;
            end
            pending_words.insert(pending_words.size(), w);
        endfunction

        function void close_field();
            case (field_index)
                art_pkg::FIELD_START:  start_hold = number_acc;
                art_pkg::FIELD_SPAN:   length_hold = number_acc;
                art_pkg::FIELD_STRAND:
                    strand_hold = field_has_byte ? number_acc[7:0] : 8'h00;
                art_pkg::FIELD_CONTIG: contig_hold = number_acc;
                default: ;
            endcase
            if (field_index < art_pkg::FIELD_SAT)
                field_index++;
            number_acc     = '0;
            field_has_byte = 1'b0;
        endfunction

        function void note_byte(logic [7:0] c);
            logic [15:0] finished;
            if (c == art_pkg::CH_SPACE)
            begin
                if (!prev_space)
                    close_field();
                prev_space = 1'b1;
                return;
            end
            prev_space = 1'b0;
            if (c == art_pkg::CH_NEWLINE)
            begin
                if (field_index == art_pkg::FIELD_SEQ)
                begin
                    if (block_count != art_pkg::COUNT_MAX)
                        block_count++;
                    push_word(art_pkg::EV_RECORD, 8'h00, 16'h0000);
                end
                if (line_start)
                begin
                    finished = block_count;
                    if (finished > max_count)
                        max_count = finished;
                    block_count = '0;
                    push_word(art_pkg::EV_BLOCK, 8'h00, finished);
                end
                line_start     = 1'b1;
                field_index    = '0;
                number_acc     = '0;
                field_has_byte = 1'b0;
                return;
            end
            if (c == art_pkg::CH_HASH)
                return;
            if (line_start)
            begin
                line_start = 1'b0;
                return;
            end
            case (field_index)
                art_pkg::FIELD_SOURCE: push_word(art_pkg::EV_SOURCE, c, 16'h0000);
                art_pkg::FIELD_START, art_pkg::FIELD_SPAN, art_pkg::FIELD_CONTIG:
                    number_acc = number_acc * 32'd10 + {24'h0, c}
                               - {24'h0, art_pkg::CH_ZERO};
                art_pkg::FIELD_STRAND:
                    if (!field_has_byte)
                        number_acc = {24'h0, c};
                art_pkg::FIELD_SEQ: push_word(art_pkg::EV_SEQ, c, 16'h0000);
                default: ;
            endcase
            field_has_byte = 1'b1;
        endfunction

        function string describe(art_pkg::result_t w);
            return $sformatf({"ev=%0d char=%02h start=%0d span=%0d strand=%02h",
                              " contig=%0d recs=%0d max=%0d"},
                             w.event_res, w.char_out, w.start_pos, w.span_len,
                             w.strand_char, w.contig_len, w.records_in_block,
                             w.max_records);
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("%s", msg);
        endfunction

        function void check_word(art_pkg::result_t seen);
            art_pkg::result_t want;
            if (pending_words.size() == 0)
            begin
                flag({"unexpected word: ", describe(seen)});
                return;
            end
            want = pending_words.pop_front();
            if (seen.event_res !== want.event_res || seen.char_out !== want.char_out
                || seen.start_pos !== want.start_pos || seen.span_len !== want.span_len
                || seen.strand_char !== want.strand_char
                || seen.contig_len !== want.contig_len
                || seen.records_in_block !== want.records_in_block
                || seen.max_records !== want.max_records)
                flag({"word mismatch: expected ", describe(want), " actual ", describe(seen)});
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    art_char_if   char_ch();
    art_result_if result_ch();

    alignment_record_tokenizer_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .char_ch   (char_ch),
        .result_ch (result_ch)
    );

    tokenizer_scoreboard sb = new();

    // idle percentages of the sender and the receiver, changed per phase
    int unsigned idle_pct;
    int unsigned stall_pct;
    // bytes accepted so far
    int unsigned counted_bytes;
    // text of the line being built, sent as a whole
    logic [7:0]  line_bytes[$];

    always #4 clk = ~clk;

    // safety net against a hung handshake
    initial
    begin
        #40ms;
        $display("Mismatches found");
        $finish;
    end

    // one byte word: optional idle gap, then hold valid until accepted.
    // valid stays high between back-to-back words so it is never lowered
    // and raised in one step
    task automatic send_byte(input logic [7:0] c);
        if ($urandom_range(0, 99) < idle_pct)
        begin
            char_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < idle_pct);
        end
        char_ch.valid   <= 1'b1;
        char_ch.char_in <= c;
        @(posedge clk);
        while (!char_ch.ready)
            @(posedge clk);
        sb.note_byte(c);
        counted_bytes++;
    endtask

    task automatic send_line();
        foreach (line_bytes[i])
            send_byte(line_bytes[i]);
        line_bytes.delete();
    endtask

    function automatic void append_byte(logic [7:0] b);
        line_bytes.insert(line_bytes.size(), b);
    endfunction

    // any byte that is not a separator, newline or comment mark
    function automatic logic [7:0] ordinary_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == art_pkg::CH_SPACE || b == art_pkg::CH_NEWLINE || b == art_pkg::CH_HASH);
        return b;
    endfunction

    function automatic void add_string(string s);
        foreach (s[i])
            append_byte(s[i]);
    endfunction

    // field separator, mostly one space, sometimes a run
    function automatic void add_gap();
        int n;
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(2, 3) : 1;
        repeat (n)
            append_byte(art_pkg::CH_SPACE);
    endfunction

    // free text with a rare swallowed '#'
    function automatic void add_text(int n);
        repeat (n)
        begin
            if ($urandom_range(0, 39) == 0)
                append_byte(art_pkg::CH_HASH);
            else
                append_byte(ordinary_byte());
        end
    endfunction

    // decimal digits, long enough to wrap, with an odd non-digit now and then
    function automatic void add_number();
        int n;
        n = $urandom_range(1, 12);
        repeat (n)
        begin
            if ($urandom_range(0, 19) == 0)
                append_byte(ordinary_byte());
            else
                append_byte(art_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
        end
    endfunction

    // alignment line with a chosen number of fields; a leading space shifts
    // every field by one and a trailing gap opens an extra field
    function automatic void add_record(int nfields, bit lead_space);
        if (lead_space)
            append_byte(art_pkg::CH_SPACE);
        if ($urandom_range(0, 3) == 0)
            append_byte(ordinary_byte());
        else
            add_string("s");
        for (int f = 1; f < nfields; f++)
        begin
            add_gap();
            case (f)
                art_pkg::FIELD_START, art_pkg::FIELD_SPAN, art_pkg::FIELD_CONTIG:
                    add_number();
                art_pkg::FIELD_STRAND:
                    case ($urandom_range(0, 4))
                        0: append_byte(art_pkg::CH_HASH);
                        1: add_text($urandom_range(1, 3));
                        default: add_string($urandom_range(0, 1) ? "+" : "-");
                    endcase
                art_pkg::FIELD_SEQ: add_text($urandom_range(1, 16));
                default: add_text($urandom_range(1, 8));
            endcase
        end
        if ($urandom_range(0, 9) == 0)
            add_gap();
        append_byte(art_pkg::CH_NEWLINE);
    endfunction

    // garbage lines: any byte value at all, or only marks and spaces
    function automatic void add_noise();
        int n;
        n = $urandom_range(1, 20);
        if ($urandom_range(0, 1) == 0)
        begin
            repeat (n)
                append_byte(8'($urandom_range(0, 255)));
        end
        else
        begin
            repeat ($urandom_range(1, 8))
            begin
                append_byte(art_pkg::CH_HASH);
                append_byte(art_pkg::CH_SPACE);
            end
        end
        append_byte(art_pkg::CH_NEWLINE);
    endfunction

    // header line, a few alignment lines, then the empty line closing it
    task automatic send_block();
        int n;
        if ($urandom_range(0, 4) != 0)
        begin
            add_string("a");
            add_gap();
            add_text($urandom_range(1, 6));
            add_number();
            append_byte(art_pkg::CH_NEWLINE);
            send_line();
        end
        n = $urandom_range(0, 4);
        repeat (n)
        begin
            case ($urandom_range(0, 9))
                0: add_record(6, 1'b0);
                1: add_record(8, 1'b0);
                2: add_record(7, 1'b1);
                3: add_noise();
                default: add_record(7, 1'b0);
            endcase
            send_line();
        end
        append_byte(art_pkg::CH_NEWLINE);
        send_line();
    endtask

    task automatic run_random(int unsigned goal);
        while (counted_bytes < goal)
            send_block();
    endtask

    // receiver: check each accepted word, then roll ready for the next edge
    initial
    begin
        art_pkg::result_t seen;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_ch.valid && result_ch.ready)
            begin
                seen.event_res        = art_pkg::event_t'(result_ch.event_res);
                seen.char_out         = result_ch.char_out;
                seen.start_pos        = result_ch.start_pos;
                seen.span_len         = result_ch.span_len;
                seen.strand_char      = result_ch.strand_char;
                seen.contig_len       = result_ch.contig_len;
                seen.records_in_block = result_ch.records_in_block;
                seen.max_records      = result_ch.max_records;
                sb.check_word(seen);
            end
            result_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    initial
    begin
        char_ch.valid   <= 1'b0;
        char_ch.char_in <= 8'h00;
        result_ch.ready <= 1'b0;
        rst_n           <= 1'b0;
        idle_pct        = 24;
        stall_pct       = 45;
        counted_bytes   = 0;
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty line straight after reset: block done with no records
        append_byte(art_pkg::CH_NEWLINE);
        send_line();
        // extreme bytes as source and sequence, a start that wraps past
        // 32 bits, a zero span and an empty strand field
        add_string("s ");
        append_byte(8'h00);
        add_string(" 9999999999 0 # 1 ");
        append_byte(8'hFF);
        append_byte(art_pkg::CH_NEWLINE);
        send_line();
        // only marks and spaces: reaches the sequence field with no
        // ordinary byte, so record done then block done on one newline
        add_string("# # # # # # ");
        append_byte(art_pkg::CH_NEWLINE);
        send_line();

        // random blocks under the three idling schemes
        run_random(700);
        idle_pct  = 45;
        stall_pct = 24;
        run_random(1400);
        idle_pct  = 0;
        stall_pct = 0;
        run_random(2000);

        char_ch.valid <= 1'b0;
        // drain, then wait on for any stray word
        while (sb.pending_words.size() != 0)
            @(posedge clk);
        repeat (8)
            @(posedge clk);
        if (sb.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### files.f
design/art_pkg.sv
design/art_if.sv
design/art_core.sv
design/art_queue.sv
design/alignment_record_tokenizer_top.sv
tb/tb.sv
